@@ src/noise_shaped_dither_quantizer_unit_defines.svh @@
// Assertion macros shared by the noise-shaped dither quantizer RTL.
`ifndef NOISE_SHAPED_DITHER_QUANTIZER_UNIT_DEFINES_SVH
`define NOISE_SHAPED_DITHER_QUANTIZER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define NSDQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define NSDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/nsdq_pkg.sv @@
// Package: widths, register indexes, sequencer codes and the microcode ROM.
`default_nettype none

package nsdq_pkg;

	localparam int RAND_BITS  = 15;
	localparam int ERROR_BITS = 32;

	localparam int SAMPLE_W   = 24;
	localparam int GAIN_W     = 15;
	localparam int DC_W       = 16;
	localparam int AMP_W      = 16;
	localparam int OBITS_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// working width of v and the quantizer sum
	localparam int WW  = 52;
	// clamped feedback term width and its pre-clamp width
	localparam int TW  = 48;
	localparam int TRW = (ERROR_BITS + 2 > TW) ? ERROR_BITS + 2 : TW;
	// shared multiplier operand and product widths
	localparam int MA_W = AMP_W + 1;
	localparam int PW   = MA_W + TW;
	localparam int GAIN_FRAC = 15;
	localparam int Q_FRAC    = 16;

	localparam logic signed [SAMPLE_W-1:0] FULL_SCALE = 24'sd4194304;

	localparam logic [GAIN_W-1:0]  GAIN_RST  = 15'd16384;
	localparam logic [DC_W-1:0]    DC_RST    = 16'd32768;
	localparam logic [AMP_W-1:0]   AMP_RST   = 16'd65535;
	localparam logic [OBITS_W-1:0] OBITS_RST = 5'd16;
	localparam logic [OBITS_W-1:0] OBITS_MIN = 5'd8;
	localparam logic [OBITS_W-1:0] OBITS_MAX = 5'd24;
	localparam logic [OBITS_W-1:0] OBITS_OFS = 5'd7;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OBITS = 2'd3;

	localparam int STEP_W = 2;
	localparam logic [STEP_W-1:0] STEP_IDLE   = 2'd0;
	localparam logic [STEP_W-1:0] STEP_MUL_FB = 2'd1;
	localparam logic [STEP_W-1:0] STEP_MUL_DI = 2'd2;
	localparam logic [STEP_W-1:0] STEP_FINISH = 2'd3;

	localparam logic [1:0] COND_ALWAYS   = 2'd0;
	localparam logic [1:0] COND_IN_FIRE  = 2'd1;
	localparam logic [1:0] COND_OUT_FREE = 2'd2;

	localparam logic MSRC_GAIN = 1'b0;
	localparam logic MSRC_AMP  = 1'b1;

	typedef struct packed {
		logic [1:0]        cond;
		logic [STEP_W-1:0] target;
		logic              mul_en;
		logic              mul_src;
		logic              add_fb;
		logic              finish;
	} ucode_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic mul_src;
		logic add_fb;
		logic finish;
	} ctrl_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		unique case (step)
			STEP_IDLE: begin
				w.cond = COND_IN_FIRE;
				w.target = STEP_MUL_FB;
			end
			STEP_MUL_FB: begin
				w.cond = COND_ALWAYS;
				w.target = STEP_MUL_DI;
				w.mul_en = 1'b1;
				w.mul_src = MSRC_GAIN;
			end
			STEP_MUL_DI: begin
				w.cond = COND_ALWAYS;
				w.target = STEP_FINISH;
				w.mul_en = 1'b1;
				w.mul_src = MSRC_AMP;
				w.add_fb = 1'b1;
			end
			STEP_FINISH: begin
				w.cond = COND_OUT_FREE;
				w.target = STEP_IDLE;
				w.finish = 1'b1;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ src/noise_shaped_dither_quantizer_unit.sv @@
// Top level: configuration registers, microcode sequencer, handshakes and output register.
//
// One sample in, one dithered sample out. An accepted transaction runs three
// microcode steps: gain times feedback term, dither amplitude times random
// delta (both on one shared 17x48 multiplier), then quantize and write back the
// error history. The result is written to the output register in the finish
// step, which waits while the output still holds an unaccepted result. No new
// transaction is taken until the sequencer is back in idle; in_stall is high
// while the sequencer is busy. The error history and previous random word are
// shared by all samples, so interleaved channels share one noise-shaping loop.
// Configuration writes are always ready and belong between transactions.
`default_nettype none
`include "noise_shaped_dither_quantizer_unit_defines.svh"

module noise_shaped_dither_quantizer_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [nsdq_pkg::SAMPLE_W-1:0]   sample_in,
	input  wire logic [nsdq_pkg::RAND_BITS-1:0]         random_value,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [nsdq_pkg::SAMPLE_W-1:0]        sample_out,
	output logic                                        clipped,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [nsdq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [nsdq_pkg::CFG_DATA_W-1:0]        cfg_data
);

	logic [nsdq_pkg::GAIN_W-1:0]         gain_q;
	logic [nsdq_pkg::DC_W-1:0]           dc_q;
	logic [nsdq_pkg::AMP_W-1:0]          amp_q;
	logic [nsdq_pkg::OBITS_W-1:0]        obits_q;

	logic [nsdq_pkg::STEP_W-1:0]         step_q;
	nsdq_pkg::ucode_t                    uw;
	nsdq_pkg::ctrl_t                     ctrl;
	logic                                cond_met;
	logic                                in_fire;

	logic                                out_valid_q;
	logic signed [nsdq_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                clipped_q;
	logic signed [nsdq_pkg::SAMPLE_W-1:0] res_sample;
	logic                                res_clip;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= nsdq_pkg::GAIN_RST;
			dc_q <= nsdq_pkg::DC_RST;
			amp_q <= nsdq_pkg::AMP_RST;
			obits_q <= nsdq_pkg::OBITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nsdq_pkg::REG_GAIN:  gain_q <= cfg_data[nsdq_pkg::GAIN_W-1:0];
				nsdq_pkg::REG_DC:    dc_q <= cfg_data;
				nsdq_pkg::REG_AMP:   amp_q <= cfg_data;
				nsdq_pkg::REG_OBITS: obits_q <= cfg_data[nsdq_pkg::OBITS_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (step_q != nsdq_pkg::STEP_IDLE);
	assign in_fire = in_valid && !in_stall;
	assign uw = nsdq_pkg::ucode_rom(step_q);

	always_comb begin
		unique case (uw.cond)
			nsdq_pkg::COND_ALWAYS:   cond_met = 1'b1;
			nsdq_pkg::COND_IN_FIRE:  cond_met = in_fire;
			nsdq_pkg::COND_OUT_FREE: cond_met = !(out_valid_q && out_stall);
			default:                 cond_met = 1'b0;
		endcase
		ctrl.load = in_fire;
		ctrl.mul_en = uw.mul_en;
		ctrl.mul_src = uw.mul_src;
		ctrl.add_fb = uw.add_fb;
		ctrl.finish = uw.finish && cond_met;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= nsdq_pkg::STEP_IDLE;
		end else if (cond_met) begin
			step_q <= uw.target;
		end
	end

	nsdq_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.sample_in(sample_in),
		.random_value(random_value),
		.shaping_gain(gain_q),
		.dc_offset(dc_q),
		.dither_amplitude(amp_q),
		.output_bits(obits_q),
		.res_sample(res_sample),
		.res_clip(res_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			sample_out_q <= res_sample;
			clipped_q <= res_clip;
		end
	end

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped = clipped_q;

	`NSDQ_ASSERT_NEXT(a_fire_starts, in_fire, step_q == nsdq_pkg::STEP_MUL_FB, "accepted transaction did not start the program")
	`NSDQ_ASSERT_SAME(a_finish_free, ctrl.finish, !(out_valid_q && out_stall), "result written over a held output")
	`NSDQ_ASSERT_NEXT(a_finish_out, ctrl.finish, out_valid_q && step_q == nsdq_pkg::STEP_IDLE, "finish did not present result and return to idle")

endmodule

`default_nettype wire

@@ src/nsdq_datapath.sv @@
// Datapath: input clamp and scaling, shared multiplier, quantizer and error history.
`default_nettype none

module nsdq_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire nsdq_pkg::ctrl_t                     ctrl,
	input  wire logic signed [nsdq_pkg::SAMPLE_W-1:0] sample_in,
	input  wire logic [nsdq_pkg::RAND_BITS-1:0]      random_value,
	input  wire logic [nsdq_pkg::GAIN_W-1:0]         shaping_gain,
	input  wire logic [nsdq_pkg::DC_W-1:0]           dc_offset,
	input  wire logic [nsdq_pkg::AMP_W-1:0]          dither_amplitude,
	input  wire logic [nsdq_pkg::OBITS_W-1:0]        output_bits,
	output logic signed [nsdq_pkg::SAMPLE_W-1:0]     res_sample,
	output logic                                     res_clip
);

	localparam int WW  = nsdq_pkg::WW;
	localparam int TW  = nsdq_pkg::TW;
	localparam int TRW = nsdq_pkg::TRW;
	localparam int PW  = nsdq_pkg::PW;
	localparam int EB  = nsdq_pkg::ERROR_BITS;
	localparam int RB  = nsdq_pkg::RAND_BITS;
	localparam int SW  = nsdq_pkg::SAMPLE_W;

	localparam logic signed [WW-1:0]  ONE_W   = {{(WW-1){1'b0}}, 1'b1};
	localparam logic signed [TRW-1:0] ONE_T   = {{(TRW-1){1'b0}}, 1'b1};
	localparam logic signed [TRW-1:0] TMAX    = (ONE_T <<< (TW-1)) - ONE_T;
	localparam logic signed [TRW-1:0] TMIN    = -(ONE_T <<< (TW-1));
	localparam logic signed [WW-1:0]  EMAX    = (ONE_W <<< (EB-1)) - ONE_W;
	localparam logic signed [WW-1:0]  EMIN    = -(ONE_W <<< (EB-1));

	logic signed [WW-1:0]               v_q;
	logic signed [TW-1:0]               t_q;
	logic signed [RB:0]                 d_q;
	logic                               clip_q;
	logic [nsdq_pkg::OBITS_W-1:0]       obits_q;
	logic signed [PW-1:0]               prod_q;
	logic [RB-1:0]                      prev_q;
	logic signed [EB-1:0]               e1_q;
	logic signed [EB-1:0]               e2_q;

	logic [nsdq_pkg::OBITS_W-1:0]       ob;
	logic [nsdq_pkg::OBITS_W-1:0]       sh;
	logic signed [SW-1:0]               x;
	logic                               x_clip;
	logic signed [WW-1:0]               x_w;
	logic signed [WW-1:0]               v_new;
	logic signed [TRW-1:0]              e1x;
	logic signed [TRW-1:0]              e2x;
	logic signed [TRW-1:0]              tw;
	logic signed [TW-1:0]               t_new;
	logic signed [RB:0]                 d_new;
	logic signed [nsdq_pkg::MA_W-1:0]   ma;
	logic signed [TW-1:0]               mb;
	logic signed [PW-1:0]               prod;
	logic signed [PW-1:0]               prod_fb;
	logic signed [PW-1:0]               prod_di;
	logic signed [WW-1:0]               sum;
	logic signed [WW-1:0]               qv;
	logic signed [WW-1:0]               errw;
	logic signed [EB-1:0]               err;
	logic signed [WW-1:0]               omax;
	logic signed [WW-1:0]               omin;

	// accept: clamp, scale to output units, form feedback term and random delta
	always_comb begin
		if (output_bits < nsdq_pkg::OBITS_MIN) ob = nsdq_pkg::OBITS_MIN;
		else if (output_bits > nsdq_pkg::OBITS_MAX) ob = nsdq_pkg::OBITS_MAX;
		else ob = output_bits;
		sh = ob - nsdq_pkg::OBITS_OFS;

		x = sample_in;
		x_clip = 1'b0;
		if (sample_in > nsdq_pkg::FULL_SCALE) begin
			x = nsdq_pkg::FULL_SCALE;
			x_clip = 1'b1;
		end else if (sample_in < -nsdq_pkg::FULL_SCALE) begin
			x = -nsdq_pkg::FULL_SCALE;
			x_clip = 1'b1;
		end
		x_w = {{(WW-SW){x[SW-1]}}, x};
		v_new = x_w <<< sh;

		e1x = {{(TRW-EB){e1_q[EB-1]}}, e1_q};
		e2x = {{(TRW-EB){e2_q[EB-1]}}, e2_q};
		tw = (e1x <<< 1) - e2x;
		if (tw > TMAX) tw = TMAX;
		else if (tw < TMIN) tw = TMIN;
		t_new = tw[TW-1:0];

		d_new = $signed({1'b0, random_value}) - $signed({1'b0, prev_q});
	end

	// shared multiplier
	always_comb begin
		if (ctrl.mul_src == nsdq_pkg::MSRC_AMP) begin
			ma = $signed({1'b0, dither_amplitude});
			mb = {{(TW-RB-1){d_q[RB]}}, d_q};
		end else begin
			ma = $signed({{(nsdq_pkg::MA_W-nsdq_pkg::GAIN_W){1'b0}}, shaping_gain});
			mb = t_q;
		end
		prod = ma * mb;
		prod_fb = prod_q >>> nsdq_pkg::GAIN_FRAC;
		prod_di = prod_q >>> RB;
	end

	// quantize, error, output saturation
	always_comb begin
		sum = v_q + $signed({{(WW-nsdq_pkg::DC_W){1'b0}}, dc_offset}) + prod_di[WW-1:0];
		qv = sum >>> nsdq_pkg::Q_FRAC;
		errw = v_q - $signed({sum[WW-1:nsdq_pkg::Q_FRAC], {nsdq_pkg::Q_FRAC{1'b0}}});
		if (errw > EMAX) err = EMAX[EB-1:0];
		else if (errw < EMIN) err = EMIN[EB-1:0];
		else err = errw[EB-1:0];

		omax = (ONE_W <<< (obits_q - 5'd1)) - ONE_W;
		omin = -(ONE_W <<< (obits_q - 5'd1));
		res_clip = clip_q;
		if (qv > omax) begin
			res_sample = omax[SW-1:0];
			res_clip = 1'b1;
		end else if (qv < omin) begin
			res_sample = omin[SW-1:0];
			res_clip = 1'b1;
		end else begin
			res_sample = qv[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			t_q <= t_new;
			d_q <= d_new;
			clip_q <= x_clip;
			obits_q <= ob;
		end
		if (ctrl.load) v_q <= v_new;
		else if (ctrl.add_fb) v_q <= v_q + prod_fb[WW-1:0];
		if (ctrl.mul_en) prod_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			e1_q <= '0;
			e2_q <= '0;
		end else begin
			if (ctrl.load) prev_q <= random_value;
			if (ctrl.finish) begin
				e2_q <= e1_q;
				e1_q <= err;
			end
		end
	end

endmodule

`default_nettype wire

@@ dv/noise_shaped_dither_quantizer_unit_checker.sv @@
// Checker for the dither quantizer: predicts each sample and compares the results.
module noise_shaped_dither_quantizer_unit_checker
	import nsdq_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic [RAND_BITS-1:0]       random_value,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample_out,
	input  wire logic                       clipped,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	output int                              errors,
	output int                              pending
);

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clip;
	} quant_t;

	quant_t expected_quant[$];

	longint gain;
	longint dc;
	longint amp;
	logic [OBITS_W-1:0] obits;
	logic [RAND_BITS-1:0] prev_word;
	longint err_last;
	longint err_older;

	function automatic quant_t quantize_sample(input logic signed [SAMPLE_W-1:0] s,
			input logic [RAND_BITS-1:0] word);
		quant_t res;
		int bits;
		longint full, x, v, t, dith, sum, q, err, hi, lo, elim, tlim;
		full = longint'(FULL_SCALE);
		elim = longint'(1) << (ERROR_BITS - 1);
		tlim = longint'(1) << 47;
		res.clip = 1'b0;
		bits = int'(obits);
		if (bits < 8) bits = 8;
		if (bits > 24) bits = 24;
		x = longint'(s);
		if (x > full) begin
			x = full;
			res.clip = 1'b1;
		end
		if (x < -full) begin
			x = -full;
			res.clip = 1'b1;
		end
		v = x * (longint'(1) << (bits - 7));
		t = 2 * err_last - err_older;
		if (t > tlim - 1) t = tlim - 1;
		if (t < -tlim) t = -tlim;
		v = v + ((gain * t) >>> GAIN_FRAC);
		dith = (amp * (longint'(word) - longint'(prev_word))) >>> RAND_BITS;
		sum = v + dc + dith;
		q = sum >>> Q_FRAC;
		err = v - q * 65536;
		if (err > elim - 1) err = elim - 1;
		if (err < -elim) err = -elim;
		err_older = err_last;
		err_last = err;
		prev_word = word;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -(longint'(1) << (bits - 1));
		if (q > hi) begin
			q = hi;
			res.clip = 1'b1;
		end
		if (q < lo) begin
			q = lo;
			res.clip = 1'b1;
		end
		res.sample = q[SAMPLE_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		quant_t want;
		if (!arst_n) begin
			gain = longint'(GAIN_RST);
			dc = longint'(DC_RST);
			amp = longint'(AMP_RST);
			obits = OBITS_RST;
			prev_word = '0;
			err_last = 0;
			err_older = 0;
			errors = 0;
			expected_quant.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN:  gain = longint'(cfg_data[GAIN_W-1:0]);
					REG_DC:    dc = longint'(cfg_data[DC_W-1:0]);
					REG_AMP:   amp = longint'(cfg_data[AMP_W-1:0]);
					REG_OBITS: obits = cfg_data[OBITS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_quant.size() == 0) begin
					if (errors < 10)
						$display("unexpected transaction: sample_out=%0d clipped=%0b",
							sample_out, clipped);
					errors++;
				end else begin
					want = expected_quant.pop_front();
					if (sample_out !== want.sample || clipped !== want.clip) begin
						if (errors < 10)
							$display("mismatch: expected %0d clipped %0b, actual %0d clipped %0b",
								want.sample, want.clip, sample_out, clipped);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_quant.push_back(quantize_sample(sample_in, random_value));
		end
		pending = expected_quant.size();
	end

endmodule

@@ dv/noise_shaped_dither_quantizer_unit_test.sv @@
// Testbench top for the dither quantizer: clock, reset, stimulus and verdict.
module noise_shaped_dither_quantizer_unit_test;
	import nsdq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic [RAND_BITS-1:0] random_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int burst_left = 0;
	int gap_max = 0;
	int stall_mode = 0;
	int stall_run = 0;
	logic stall_level = 1'b0;

	int directed_x[20] = '{0, 1, -1, 4194304, -4194304, 4194305, -4194305, 8388607,
		-8388608, 4194303, -4194303, 2097152, -2097152, 12345, -12345, 4194304,
		4194304, -4194304, 0, 0};
	int directed_r[20] = '{0, 32767, 0, 32767, 0, 32767, 0, 1, 32766, 16384, 0,
		32767, 32767, 0, 16383, 0, 32767, 32767, 0, 32767};
	logic [CFG_DATA_W-1:0] fixed_cfg[4][4] = '{
		'{16'h0000, 16'h0000, 16'h0000, 16'h0003},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{16'h7FFF, 16'h0000, 16'hFFFF, 16'h0008},
		'{16'h0001, 16'hFFFF, 16'h8000, 16'h0018}};

	always #5 clk = ~clk;

	noise_shaped_dither_quantizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.random_value(random_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.clipped(clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	noise_shaped_dither_quantizer_unit_checker quant_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.random_value(random_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.clipped(clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	// receiver back-pressure: none, random, or alternating runs
	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_run == 0) begin
					stall_run = $urandom_range(1, 12);
					stall_level = ~stall_level;
				end
				stall_run--;
				out_stall <= stall_level;
			end
		endcase
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s,
			input logic [RAND_BITS-1:0] r);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		sample_in <= s;
		random_value <= r;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		burst_left = 0;
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int v;
		case ($urandom_range(0, 9))
			0, 1: v = int'($urandom);
			2: v = ($urandom_range(0, 1) ? 4194304 : -4194304) + $urandom_range(0, 8) - 4;
			default: v = int'($urandom_range(0, 8388608)) - 4194304;
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [RAND_BITS-1:0] random_word();
		logic [31:0] w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = 32'd32767;
			default: w = $urandom;
		endcase
		return w[RAND_BITS-1:0];
	endfunction

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0] word;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_max = 4;
		stall_mode = 1;
		for (int i = 0; i < 20; i++)
			send_sample(directed_x[i][SAMPLE_W-1:0], directed_r[i][RAND_BITS-1:0]);

		for (int p = 1; p <= 8; p++) begin
			wait_drained();
			for (int k = 0; k < 4; k++) begin
				if (p <= 4) begin
					word = fixed_cfg[p-1][k];
				end else if (k == REG_OBITS) begin
					word = CFG_DATA_W'($urandom);
					if ($urandom_range(0, 4) != 0)
						word[OBITS_W-1:0] = OBITS_W'($urandom_range(8, 24));
				end else begin
					word = CFG_DATA_W'($urandom);
				end
				write_reg(k[CFG_IDX_W-1:0], word);
			end
			cfg_valid <= 1'b0;
			@(negedge clk);
			if (p == 1) begin
				gap_max = 0;
				stall_mode = 0;
			end else begin
				gap_max = $urandom_range(0, 10);
				stall_mode = $urandom_range(0, 2);
			end
			for (int i = 0; i < 80; i++) begin
				if ($urandom_range(0, 39) == 0)
					wait_drained();
				send_sample(random_sample(), random_word());
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
